>>> hw/rtl/multiplexed_segment_display_defines.svh
// Assertion macros used by the display engine RTL.
`ifndef MULTIPLEXED_SEGMENT_DISPLAY_DEFINES_SVH
`define MULTIPLEXED_SEGMENT_DISPLAY_DEFINES_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msd assertion failed");
`define MSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msd assertion failed");
`else
`define MSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MSD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/msd_pkg.sv
`timescale 1ns / 1ps

package msd_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_NUMBER = 3'd1;
    localparam logic [2:0] OP_TIME   = 3'd2;
    localparam logic [2:0] OP_TEXT   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_FOCUS  = 3'd5;

    localparam logic CFG_DWELL = 1'b0;
    localparam logic CFG_BLANK = 1'b1;

    localparam int POSITIONS   = 5;
    localparam int CONV_STAGES = 8;

    localparam logic [15:0] MAX_NUMBER   = 16'd9999;
    localparam logic [2:0]  LIT_DIGITS   = 3'd4;
    localparam logic [7:0]  DECIMAL_BIT  = 8'h01;
    localparam logic [7:0]  COLON_ON     = 8'hff;
    localparam logic [15:0] DWELL_RESET  = 16'd2000;
    localparam logic [4:0]  BLANK_RESET  = 5'd16;
    localparam logic [7:0]  SEGMENT_OFF  = 8'hff;

    // Reciprocal constants for exact division over the value ranges used.
    localparam logic [28:0] MUL_DIV1000 = 29'd274877907;
    localparam logic [22:0] MUL_DIV60S  = 23'd4473925;
    localparam logic [22:0] MUL_DIV3600 = 23'd4772186;
    localparam logic [18:0] MUL_DIV60M  = 19'd279621;
    localparam logic [12:0] MUL_DIV100  = 13'd5243;
    localparam logic [7:0]  MUL_DIV10   = 8'd205;

    localparam logic [13:0] PLACE_FLOOR [1:4] = '{14'd1, 14'd10, 14'd100, 14'd1000};

    localparam logic [7:0] GLYPHS [0:35] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6,
        8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e, 8'hbc, 8'h6e, 8'h0c, 8'h78,
        8'h00, 8'h1c, 8'h00, 8'h2a, 8'hfc, 8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e,
        8'h7c, 8'h00, 8'h00, 8'h00, 8'h76, 8'hda
    };

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       frame;
        logic [15:0]      number;
        logic [2:0]       precision;
        logic [3:0][7:0]  text;
    } item_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       frame;
        logic             rejected;
        logic [4:0][7:0]  bytes;
        logic [4:0]       mask;
    } conv_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        g = 8'h00;
        if (d inside {[4'd0:4'd9]})
        begin
            g = GLYPHS[6'(d)];
        end
        return g;
    endfunction

    function automatic logic [7:0] char_glyph(input logic [7:0] c);
        logic [7:0] g;
        g = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            g = GLYPHS[6'(c - 8'd48)];
        end
        else if (c inside {[8'h41:8'h5a]})
        begin
            g = GLYPHS[6'(c - 8'd55)];
        end
        else if (c inside {[8'h61:8'h7a]})
        begin
            g = GLYPHS[6'(c - 8'd87)];
        end
        return g;
    endfunction

endpackage

>>> hw/rtl/msd_convert.sv
`timescale 1ns / 1ps

module msd_convert #(
    parameter int FRAME_SLOTS = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             item_valid,
    input  msd_pkg::item_t   item,
    input  logic [31:0]      time_ms,
    output logic             conv_valid,
    output msd_pkg::conv_t   conv
);

    localparam int ST = msd_pkg::CONV_STAGES;

    logic [ST-1:0]    valid_reg;
    msd_pkg::item_t   item_reg [ST];

    logic [31:0] tms0_reg;
    logic [22:0] secs1_reg;
    logic [22:0] secs2_reg;
    logic [16:0] mt2_reg;
    logic [10:0] hr2_reg;
    logic [5:0]  sec3_reg;
    logic [16:0] mt3_reg;
    logic [10:0] hr3_reg;
    logic [10:0] mh3_reg;
    logic [13:0] value4_reg;
    logic [13:0] value5_reg;
    logic [6:0]  hi5_reg;
    logic [13:0] value6_reg;
    logic [6:0]  hi6_reg;
    logic [6:0]  lo6_reg;
    logic [13:0] value7_reg;
    logic [6:0]  hi7_reg;
    logic [6:0]  lo7_reg;
    logic [3:0]  thi7_reg;
    logic [3:0]  tlo7_reg;

    logic [60:0] prod1;
    logic [45:0] prod_min;
    logic [45:0] prod_hr;
    logic [35:0] prod_mh;
    logic [22:0] sec_rem;
    logic [16:0] min_rem;
    logic [6:0]  hr_sat;
    logic [13:0] time_value;
    logic [13:0] value_next;
    logic [26:0] prod_hi;
    logic [13:0] lo_rem;
    logic [14:0] prod_thi;
    logic [14:0] prod_tlo;

    assign prod1    = 61'(tms0_reg) * 61'(msd_pkg::MUL_DIV1000);
    assign prod_min = 46'(secs1_reg) * 46'(msd_pkg::MUL_DIV60S);
    assign prod_hr  = 46'(secs1_reg) * 46'(msd_pkg::MUL_DIV3600);
    assign prod_mh  = 36'(mt2_reg) * 36'(msd_pkg::MUL_DIV60M);
    assign sec_rem  = secs2_reg - 23'(mt2_reg) * 23'd60;
    assign min_rem  = mt3_reg - 17'(mh3_reg) * 17'd60;
    assign hr_sat   = (hr3_reg > 11'd99) ? 7'd99 : hr3_reg[6:0];

    always_comb
    begin
        if (hr_sat != 7'd0)
        begin
            time_value = 14'(hr_sat) * 14'd100 + 14'(min_rem[5:0]);
        end
        else
        begin
            time_value = 14'(min_rem[5:0]) * 14'd100 + 14'(sec3_reg);
        end
        if (item_reg[3].op == msd_pkg::OP_TIME)
        begin
            value_next = time_value;
        end
        else
        begin
            value_next = item_reg[3].number[13:0];
        end
    end

    assign prod_hi  = 27'(value4_reg) * 27'(msd_pkg::MUL_DIV100);
    assign lo_rem   = value5_reg - 14'(hi5_reg) * 14'd100;
    assign prod_thi = 15'(hi6_reg) * 15'(msd_pkg::MUL_DIV10);
    assign prod_tlo = 15'(lo6_reg) * 15'(msd_pkg::MUL_DIV10);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[ST-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg[0] <= item;
            for (int i = 1; i < ST; i++)
            begin
                item_reg[i] <= item_reg[i-1];
            end
            tms0_reg   <= time_ms;
            secs1_reg  <= prod1[60:38];
            secs2_reg  <= secs1_reg;
            mt2_reg    <= prod_min[44:28];
            hr2_reg    <= prod_hr[44:34];
            sec3_reg   <= sec_rem[5:0];
            mt3_reg    <= mt2_reg;
            hr3_reg    <= hr2_reg;
            mh3_reg    <= prod_mh[34:24];
            value4_reg <= value_next;
            value5_reg <= value4_reg;
            hi5_reg    <= prod_hi[25:19];
            value6_reg <= value5_reg;
            hi6_reg    <= hi5_reg;
            lo6_reg    <= lo_rem[6:0];
            value7_reg <= value6_reg;
            hi7_reg    <= hi6_reg;
            lo7_reg    <= lo6_reg;
            thi7_reg   <= prod_thi[14:11];
            tlo7_reg   <= prod_tlo[14:11];
        end
    end

    msd_pkg::item_t fin;
    logic [6:0]     ones_hi;
    logic [6:0]     ones_lo;
    logic [3:0]     dig [1:4];
    logic [2:0]     prec;
    logic [3:0]     pad;
    logic           number_bad;
    logic           frame_bad;

    assign fin     = item_reg[ST-1];
    assign ones_lo = lo7_reg - 7'(tlo7_reg) * 7'd10;
    assign ones_hi = hi7_reg - 7'(thi7_reg) * 7'd10;

    always_comb
    begin
        dig[1] = ones_lo[3:0];
        dig[2] = tlo7_reg;
        dig[3] = ones_hi[3:0];
        dig[4] = thi7_reg;
        prec = (fin.op == msd_pkg::OP_TIME) ? 3'd3 : fin.precision;
        pad = (prec == 3'd0) ? 4'd2 : 4'(prec) + 4'd2;
        frame_bad = 4'(fin.frame) >= 4'(FRAME_SLOTS);
        number_bad = (fin.number > msd_pkg::MAX_NUMBER) || (fin.precision >= msd_pkg::LIT_DIGITS);

        conv.op = fin.op;
        conv.frame = fin.frame;
        conv.rejected = 1'b0;
        conv.bytes = '0;
        conv.mask = '1;

        case (fin.op)
            msd_pkg::OP_NUMBER:
            begin
                conv.rejected = frame_bad || number_bad;
            end
            msd_pkg::OP_TIME, msd_pkg::OP_TEXT, msd_pkg::OP_FOCUS:
            begin
                conv.rejected = frame_bad;
            end
            default:
            begin
                conv.rejected = 1'b0;
            end
        endcase

        if (fin.op == msd_pkg::OP_TEXT)
        begin
            for (int k = 0; k < 4; k++)
            begin
                conv.bytes[4-k] = msd_pkg::char_glyph(fin.text[k]);
            end
            conv.mask[4] = fin.text[0] != 8'd0;
            conv.mask[3] = conv.mask[4] && (fin.text[1] != 8'd0);
            conv.mask[2] = conv.mask[3] && (fin.text[2] != 8'd0);
            conv.mask[1] = conv.mask[2] && (fin.text[3] != 8'd0);
        end
        else
        begin
            for (int i = 1; i <= 4; i++)
            begin
                if ((value7_reg >= msd_pkg::PLACE_FLOOR[i]) || (4'(i) < pad))
                begin
                    conv.bytes[i] = msd_pkg::digit_glyph(dig[i]);
                end
                if ((fin.op == msd_pkg::OP_NUMBER) && (prec != 3'd0)
                    && (4'(prec) + 4'd1 == 4'(i)))
                begin
                    conv.bytes[i] = conv.bytes[i] | msd_pkg::DECIMAL_BIT;
                end
            end
            if (fin.op == msd_pkg::OP_TIME)
            begin
                conv.bytes[0] = msd_pkg::COLON_ON;
            end
        end
    end

    assign conv_valid = valid_reg[ST-1];

endmodule

>>> hw/rtl/msd_engine.sv
`timescale 1ns / 1ps
`include "multiplexed_segment_display_defines.svh"

module msd_engine #(
    parameter int FRAME_SLOTS = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             commit,
    input  msd_pkg::conv_t   conv,
    output logic [7:0]       segment_lines,
    output logic [4:0]       digit_enables,
    output logic [31:0]      millis_now,
    output logic [2:0]       shown_frame,
    output logic             rejected
);

    localparam int FW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CW = $clog2(FRAME_SLOTS + 1);
    localparam int NP = msd_pkg::POSITIONS;

    logic [7:0]    store_reg  [FRAME_SLOTS][NP];
    logic [7:0]    store_next [FRAME_SLOTS][NP];
    logic [CW-1:0] active_reg, active_next;
    logic [FW-1:0] focus_reg, focus_next;
    logic [5:0]    scan_reg, scan_next;
    logic          half_reg, half_next;
    logic [31:0]   millis_reg, millis_next;
    logic [31:0]   dwell_start_reg, dwell_start_next;
    logic [7:0]    segment_reg, segment_next;
    logic [4:0]    enable_reg, enable_next;
    logic          rejected_reg;
    logic [15:0]   dwell_ms_reg;
    logic [4:0]    blank_reg;

    logic [FW-1:0] frame_idx;
    logic [CW-1:0] focus_inc;
    logic [5:0]    scan_inc;

    assign frame_idx = conv.frame[FW-1:0];
    assign focus_inc = CW'(focus_reg) + CW'(1);
    assign scan_inc  = scan_reg + 6'd1;

    always_comb
    begin
        store_next       = store_reg;
        active_next      = active_reg;
        focus_next       = focus_reg;
        scan_next        = scan_reg;
        half_next        = half_reg;
        millis_next      = millis_reg;
        dwell_start_next = dwell_start_reg;
        segment_next     = segment_reg;
        enable_next      = enable_reg;
        if (commit)
        begin
            case (conv.op)
                msd_pkg::OP_TICK:
                begin
                    half_next = !half_reg;
                    millis_next = millis_reg + 32'(half_next);
                    enable_next = 5'd0;
                    if (active_reg != '0)
                    begin
                        if (scan_reg < 6'(NP))
                        begin
                            segment_next = ~store_reg[focus_reg][scan_reg[2:0]];
                            enable_next = 5'd1 << scan_reg[2:0];
                        end
                        if ((millis_next - dwell_start_reg) > 32'(dwell_ms_reg))
                        begin
                            focus_next = (focus_inc >= active_reg) ? '0 : focus_inc[FW-1:0];
                            dwell_start_next = millis_next;
                        end
                        scan_next = (scan_inc >= 6'(NP) + 6'(blank_reg)) ? 6'd0 : scan_inc;
                    end
                end
                msd_pkg::OP_NUMBER, msd_pkg::OP_TIME, msd_pkg::OP_TEXT:
                begin
                    if (!conv.rejected)
                    begin
                        for (int p = 0; p < NP; p++)
                        begin
                            if (conv.mask[p])
                            begin
                                store_next[frame_idx][p] = conv.bytes[p];
                            end
                        end
                        if (4'(conv.frame) >= 4'(active_reg))
                        begin
                            active_next = CW'(4'(conv.frame) + 4'd1);
                        end
                        focus_next = frame_idx;
                        dwell_start_next = millis_reg;
                    end
                end
                msd_pkg::OP_CLEAR:
                begin
                    for (int f = 0; f < FRAME_SLOTS; f++)
                    begin
                        for (int p = 0; p < NP; p++)
                        begin
                            store_next[f][p] = 8'h00;
                        end
                    end
                    active_next = '0;
                end
                msd_pkg::OP_FOCUS:
                begin
                    if (!conv.rejected)
                    begin
                        focus_next = frame_idx;
                        dwell_start_next = millis_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FRAME_SLOTS; f++)
            begin
                for (int p = 0; p < NP; p++)
                begin
                    store_reg[f][p] <= 8'h00;
                end
            end
            active_reg      <= '0;
            focus_reg       <= '0;
            scan_reg        <= 6'd0;
            half_reg        <= 1'b0;
            millis_reg      <= 32'd0;
            dwell_start_reg <= 32'd0;
            segment_reg     <= msd_pkg::SEGMENT_OFF;
            enable_reg      <= 5'd0;
            rejected_reg    <= 1'b0;
            dwell_ms_reg    <= msd_pkg::DWELL_RESET;
            blank_reg       <= msd_pkg::BLANK_RESET;
        end
        else
        begin
            store_reg       <= store_next;
            active_reg      <= active_next;
            focus_reg       <= focus_next;
            scan_reg        <= scan_next;
            half_reg        <= half_next;
            millis_reg      <= millis_next;
            dwell_start_reg <= dwell_start_next;
            segment_reg     <= segment_next;
            enable_reg      <= enable_next;
            if (commit)
            begin
                rejected_reg <= conv.rejected;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    msd_pkg::CFG_DWELL:
                    begin
                        dwell_ms_reg <= cfg_data;
                    end
                    msd_pkg::CFG_BLANK:
                    begin
                        blank_reg <= cfg_data[4:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign segment_lines = segment_reg;
    assign digit_enables = enable_reg;
    assign millis_now    = millis_reg;
    assign shown_frame   = 3'(focus_reg);
    assign rejected      = rejected_reg;

    `MSD_ASSERT_IMP(a_enable_onehot, clk, rst_n, 1'b1, $onehot0(enable_reg))
    `MSD_ASSERT_IMP(a_focus_range, clk, rst_n, 1'b1, 4'(focus_reg) < 4'(FRAME_SLOTS))
    `MSD_ASSERT_IMP(a_active_range, clk, rst_n, 1'b1, 4'(active_reg) <= 4'(FRAME_SLOTS))
    `MSD_ASSERT_NXT(a_clear_empties, clk, rst_n, commit && (conv.op == msd_pkg::OP_CLEAR), active_reg == '0)
    `MSD_ASSERT_NXT(a_idle_holds, clk, rst_n, !commit, $stable(millis_reg) && $stable(focus_reg))

endmodule

>>> hw/rtl/multiplexed_segment_display.sv
`timescale 1ns / 1ps
// Multiplexed seven-segment driver for a colon plus four digits, with a
// small store of frames.
// Input channel: one transaction per item (tick, write number, write time,
// write text, clear, focus), accepted when in_valid is high and in_stall low.
// Output channel: exactly one transaction per input item, in order, carrying
// the segment and digit enable latches, the millisecond count, the frame
// being scanned and the reject flag.
// From acceptance to out_valid, the input register is followed by seven
// conversion stages (seconds, minutes and hours split, then decimal digit
// split, each through a reciprocal multiply) and the state register.
// Throughput is one item per cycle while the output is taken.
// When the receiver holds out_stall with a result waiting, the whole pipeline
// freezes and in_stall is raised; nothing is lost or repeated.
// Reset clears the frame store, counters and focus, turns all segments off
// and loads dwell 2000 ms and 16 blank slots. Configuration writes take
// effect on the clock edge where cfg_write is high.

module multiplexed_segment_display #(
    parameter int FRAME_SLOTS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   operation,
    input  logic [2:0]   frame,
    input  logic [15:0]  number,
    input  logic [2:0]   precision,
    input  logic [31:0]  time_ms,
    input  logic [7:0]   text_char0,
    input  logic [7:0]   text_char1,
    input  logic [7:0]   text_char2,
    input  logic [7:0]   text_char3,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   segment_lines,
    output logic [4:0]   digit_enables,
    output logic [31:0]  millis_now,
    output logic [2:0]   shown_frame,
    output logic         rejected
);

    logic             advance;
    logic             out_valid_reg;
    logic             conv_valid;
    msd_pkg::item_t   item;
    msd_pkg::conv_t   conv;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        item.op        = operation;
        item.frame     = frame;
        item.number    = number;
        item.precision = precision;
        item.text[0]   = text_char0;
        item.text[1]   = text_char1;
        item.text[2]   = text_char2;
        item.text[3]   = text_char3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= conv_valid;
        end
    end

    assign out_valid = out_valid_reg;

    msd_convert #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (in_valid),
        .item       (item),
        .time_ms    (time_ms),
        .conv_valid (conv_valid),
        .conv       (conv)
    );

    msd_engine #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .commit        (advance && conv_valid),
        .conv          (conv),
        .segment_lines (segment_lines),
        .digit_enables (digit_enables),
        .millis_now    (millis_now),
        .shown_frame   (shown_frame),
        .rejected      (rejected)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          FRAME_SLOTS = 3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_PAD   = 12;
    localparam logic [2:0]  OP_SPARE_A  = 3'd6;
    localparam logic [2:0]  OP_SPARE_B  = 3'd7;
    localparam logic [7:0]  POINT_BIT   = 8'h01;
    localparam logic [7:0]  COLON_LIT   = 8'hff;

    localparam logic [7:0] SEG_FONT [36] = '{
        8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6,
        8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e, 8'hbc, 8'h6e, 8'h0c, 8'h78,
        8'h00, 8'h1c, 8'h00, 8'h2a, 8'hfc, 8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e,
        8'h7c, 8'h00, 8'h00, 8'h00, 8'h76, 8'hda
    };

    typedef struct packed {
        logic [2:0]       op;
        logic [2:0]       frame;
        logic [15:0]      number;
        logic [2:0]       precision;
        logic [31:0]      time_ms;
        logic [3:0][7:0]  text;
    } display_req_t;

    typedef struct packed {
        logic [7:0]   segments;
        logic [4:0]   enables;
        logic [31:0]  millis;
        logic [2:0]   frame;
        logic         rej;
    } display_view_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_write = 1'b0;
    logic         cfg_index = 1'b0;
    logic [15:0]  cfg_data = '0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [2:0]   operation = '0;
    logic [2:0]   frame = '0;
    logic [15:0]  number = '0;
    logic [2:0]   precision = '0;
    logic [31:0]  time_ms = '0;
    logic [7:0]   text_char0 = '0;
    logic [7:0]   text_char1 = '0;
    logic [7:0]   text_char2 = '0;
    logic [7:0]   text_char3 = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [7:0]   segment_lines;
    logic [4:0]   digit_enables;
    logic [31:0]  millis_now;
    logic [2:0]   shown_frame;
    logic         rejected;

    logic [7:0]   frame_bytes [FRAME_SLOTS][5];
    int unsigned  lit_frames = 0;
    logic [2:0]   cur_frame = '0;
    int unsigned  slot = 0;
    logic         half_phase = 1'b0;
    logic [31:0]  ms_count = '0;
    logic [31:0]  dwell_mark = '0;
    logic [7:0]   seg_hold = 8'hff;
    logic [4:0]   en_hold = '0;
    logic [15:0]  dwell_cfg = 16'd2000;
    logic [4:0]   blank_cfg = 5'd16;

    display_view_t expected_views [$];
    display_view_t head_view;

    int err_count = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    int rejects_predicted = 0;
    int results_checked = 0;
    int burst_left = 0;
    int max_gap = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;

    multiplexed_segment_display #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .frame(frame),
        .number(number),
        .precision(precision),
        .time_ms(time_ms),
        .text_char0(text_char0),
        .text_char1(text_char1),
        .text_char2(text_char2),
        .text_char3(text_char3),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .segment_lines(segment_lines),
        .digit_enables(digit_enables),
        .millis_now(millis_now),
        .shown_frame(shown_frame),
        .rejected(rejected)
    );

    always #4 clk = ~clk;

    initial
    begin
        foreach (frame_bytes[i, j])
        begin
            frame_bytes[i][j] = 8'h00;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            stall_left <= $urandom_range(5);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_views.size() == 0)
            begin
                $error("result transaction arrived with nothing expected");
                err_count++;
            end
            else
            begin
                head_view = expected_views.pop_front();
                results_checked++;
                if (segment_lines !== head_view.segments)
                begin
                    $error("segment_lines expected %h got %h", head_view.segments,
                           segment_lines);
                    err_count++;
                end
                if (digit_enables !== head_view.enables)
                begin
                    $error("digit_enables expected %h got %h", head_view.enables,
                           digit_enables);
                    err_count++;
                end
                if (millis_now !== head_view.millis)
                begin
                    $error("millis_now expected %0d got %0d", head_view.millis, millis_now);
                    err_count++;
                end
                if (shown_frame !== head_view.frame)
                begin
                    $error("shown_frame expected %0d got %0d", head_view.frame, shown_frame);
                    err_count++;
                end
                if (rejected !== head_view.rej)
                begin
                    $error("rejected expected %0d got %0d", head_view.rej, rejected);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [7:0] glyph_for(input logic [7:0] c);
        logic [7:0] g;
        g = 8'h00;
        if (c >= "0" && c <= "9")
        begin
            g = SEG_FONT[c - "0"];
        end
        else if (c >= "A" && c <= "Z")
        begin
            g = SEG_FONT[c - "A" + 10];
        end
        else if (c >= "a" && c <= "z")
        begin
            g = SEG_FONT[c - "a" + 10];
        end
        return g;
    endfunction

    function automatic void focus_written(input int f);
        if (f >= lit_frames)
        begin
            lit_frames = f + 1;
        end
        cur_frame = 3'(f);
        dwell_mark = ms_count;
    endfunction

    function automatic void fill_number(input int f, input int unsigned n,
                                        input int unsigned prec);
        int unsigned pad;
        pad = (prec != 0) ? prec + 2 : 2;
        for (int i = 1; i <= 4; i++)
        begin
            frame_bytes[f][i] = (n != 0 || i < pad) ? SEG_FONT[n % 10] : 8'h00;
            n = n / 10;
        end
        if (prec != 0)
        begin
            frame_bytes[f][prec + 1] |= POINT_BIT;
        end
        frame_bytes[f][0] = 8'h00;
        focus_written(f);
    endfunction

    function automatic void display_next(input display_req_t req);
        logic         rej;
        logic [31:0]  elapsed;
        int unsigned  secs;
        int unsigned  hours;
        int unsigned  pos;
        int           f;
        rej = 1'b0;
        f = req.frame;
        case (req.op)
            msd_pkg::OP_TICK:
            begin
                half_phase = ~half_phase;
                if (half_phase)
                begin
                    ms_count = ms_count + 1;
                end
                en_hold = '0;
                if (lit_frames != 0)
                begin
                    if (slot < 5)
                    begin
                        seg_hold = ~frame_bytes[cur_frame][slot];
                        en_hold = 5'(1 << slot);
                    end
                    elapsed = ms_count - dwell_mark;
                    if (elapsed > {16'd0, dwell_cfg})
                    begin
                        cur_frame = cur_frame + 1;
                        if (cur_frame >= lit_frames)
                        begin
                            cur_frame = '0;
                        end
                        dwell_mark = ms_count;
                    end
                    slot++;
                    if (slot >= 5 + blank_cfg)
                    begin
                        slot = 0;
                    end
                end
            end
            msd_pkg::OP_NUMBER:
            begin
                if (f >= FRAME_SLOTS || req.number > 9999 || req.precision >= 4)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    fill_number(f, req.number, req.precision);
                end
            end
            msd_pkg::OP_TIME:
            begin
                if (f >= FRAME_SLOTS)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    secs = req.time_ms / 1000;
                    hours = secs / 3600;
                    if (hours > 99)
                    begin
                        hours = 99;
                    end
                    if (hours != 0)
                    begin
                        fill_number(f, hours * 100 + (secs / 60) % 60, 3);
                    end
                    else
                    begin
                        fill_number(f, ((secs / 60) % 60) * 100 + secs % 60, 3);
                    end
                    frame_bytes[f][4] &= ~POINT_BIT;
                    frame_bytes[f][0] = COLON_LIT;
                end
            end
            msd_pkg::OP_TEXT:
            begin
                if (f >= FRAME_SLOTS)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    pos = 4;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (req.text[k] == 8'h00)
                        begin
                            break;
                        end
                        frame_bytes[f][pos] = glyph_for(req.text[k]);
                        pos--;
                    end
                    frame_bytes[f][0] = 8'h00;
                    focus_written(f);
                end
            end
            msd_pkg::OP_CLEAR:
            begin
                foreach (frame_bytes[i, j])
                begin
                    frame_bytes[i][j] = 8'h00;
                end
                lit_frames = 0;
            end
            msd_pkg::OP_FOCUS:
            begin
                if (f >= FRAME_SLOTS)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    cur_frame = 3'(f);
                    dwell_mark = ms_count;
                end
            end
            default:
            begin
            end
        endcase
        if (rej)
        begin
            rejects_predicted++;
        end
        expected_views.push_back('{seg_hold, en_hold, ms_count, cur_frame, rej});
    endfunction

    function automatic display_req_t make_req(input logic [2:0] op, input logic [2:0] f,
                                              input logic [15:0] n, input logic [2:0] prec,
                                              input logic [31:0] tms,
                                              input logic [31:0] chars);
        display_req_t r;
        r.op = op;
        r.frame = f;
        r.number = n;
        r.precision = prec;
        r.time_ms = tms;
        r.text = chars;
        return r;
    endfunction

    function automatic logic [7:0] random_char();
        int unsigned v;
        int unsigned t;
        logic [7:0] c;
        t = $urandom_range(19);
        v = $urandom_range(61);
        if (t < 14)
        begin
            c = (v < 10) ? 8'("0" + v) : (v < 36) ? 8'("A" + v - 10) : 8'("a" + v - 36);
        end
        else if (t < 17)
        begin
            c = 8'($urandom_range(255));
        end
        else
        begin
            c = 8'h00;
        end
        return c;
    endfunction

    function automatic display_req_t random_req();
        display_req_t r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            r.op = msd_pkg::OP_TICK;
        end
        else if (pick < 69)
        begin
            r.op = msd_pkg::OP_NUMBER;
        end
        else if (pick < 78)
        begin
            r.op = msd_pkg::OP_TIME;
        end
        else if (pick < 88)
        begin
            r.op = msd_pkg::OP_TEXT;
        end
        else if (pick < 92)
        begin
            r.op = msd_pkg::OP_FOCUS;
        end
        else if (pick < 94)
        begin
            r.op = msd_pkg::OP_CLEAR;
        end
        else if (pick < 96)
        begin
            r.op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
        end
        else
        begin
            r.op = 3'($urandom_range(7));
        end
        r.frame = ($urandom_range(9) < 8) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
        r.number = ($urandom_range(9) < 7) ? 16'($urandom_range(9999))
                                           : 16'($urandom_range(65535));
        r.precision = ($urandom_range(9) < 8) ? 3'($urandom_range(3))
                                              : 3'($urandom_range(7));
        case ($urandom_range(2))
            0: r.time_ms = $urandom_range(3599999);
            1: r.time_ms = $urandom_range(400000000);
            default: r.time_ms = $urandom();
        endcase
        for (int k = 0; k < 4; k++)
        begin
            r.text[k] = random_char();
        end
        return r;
    endfunction

    task automatic send_req(input display_req_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= req.op;
        frame <= req.frame;
        number <= req.number;
        precision <= req.precision;
        time_ms <= req.time_ms;
        text_char0 <= req.text[0];
        text_char1 <= req.text[1];
        text_char2 <= req.text[2];
        text_char3 <= req.text[3];
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        display_next(req);
        items_sent++;
        if (req.op == msd_pkg::OP_TICK)
        begin
            ticks_sent++;
        end
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_req(make_req(msd_pkg::OP_TICK, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == msd_pkg::CFG_DWELL)
        begin
            dwell_cfg = value;
        end
        else
        begin
            blank_cfg = value[4:0];
        end
    endtask

    task automatic test_directed_cases();
        stall_pct = 0;
        max_gap = 0;
        send_req(make_req(msd_pkg::OP_TICK, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd1, 16'd9999, 3'd3, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd0, 16'd10000, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd0, 16'hffff, 3'd7, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd2, 16'd42, 3'd4, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd3, 16'd5, 3'd1, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd2, 16'd7, 3'd2, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd1, 16'd0, 3'd0, 32'd59999, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd2, 16'd0, 3'd0, 32'd3600000, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd0, 16'd0, 3'd0, 32'hffffffff, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd7, 16'd0, 3'd0, 32'd1000, 32'd0));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd1, 16'd0, 3'd0, 32'd0,
                          {"z", "A", "9", "0"}));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd2, 16'd0, 3'd0, 32'd0,
                          {"!", "y", "x", "w"}));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd0, 16'd0, 3'd0, 32'd0,
                          {"Z", 8'h00, "k", "M"}));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd6, 16'd0, 3'd0, 32'd0,
                          {"1", "2", "3", "4"}));
        send_req(make_req(OP_SPARE_A, 3'd1, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(OP_SPARE_B, 3'd2, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_FOCUS, 3'd2, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_FOCUS, 3'd5, 16'd0, 3'd0, 32'd0, 32'd0));
        send_ticks(2);
        send_req(make_req(msd_pkg::OP_CLEAR, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_ticks(1);
        wait_idle();
    endtask

    task automatic test_scan_and_rotation();
        write_reg(msd_pkg::CFG_BLANK, 16'd0);
        write_reg(msd_pkg::CFG_DWELL, 16'd0);
        stall_pct = 25;
        max_gap = 3;
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd0, 16'd1234, 3'd1, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_TIME, 3'd1, 16'd0, 3'd0, 32'd754000, 32'd0));
        send_req(make_req(msd_pkg::OP_TEXT, 3'd2, 16'd0, 3'd0, 32'd0,
                          {"d", "c", "b", "A"}));
        send_ticks(60);
        wait_idle();
        write_reg(msd_pkg::CFG_BLANK, 16'hffff);
        write_reg(msd_pkg::CFG_DWELL, 16'hffff);
        send_ticks(30);
        wait_idle();
        write_reg(msd_pkg::CFG_BLANK, 16'd0);
        send_ticks(12);
        send_req(make_req(msd_pkg::OP_CLEAR, 3'd0, 16'd0, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_NUMBER, 3'd0, 16'd88, 3'd0, 32'd0, 32'd0));
        send_req(make_req(msd_pkg::OP_FOCUS, 3'd2, 16'd0, 3'd0, 32'd0, 32'd0));
        send_ticks(8);
        wait_idle();
        write_reg(msd_pkg::CFG_DWELL, 16'd1);
        send_ticks(20);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int count, input logic [15:0] dwell,
                                       input logic [15:0] blank, input int stall,
                                       input int gap);
        write_reg(msd_pkg::CFG_DWELL, dwell);
        write_reg(msd_pkg::CFG_BLANK, blank);
        stall_pct = stall;
        max_gap = gap;
        for (int i = 0; i < count; i++)
        begin
            send_req(random_req());
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_scan_and_rotation();
        test_random_traffic(220, 16'd3, 16'd0, 0, 0);
        test_random_traffic(220, 16'd0, 16'd31, 30, 4);
        test_random_traffic(180, 16'hffff, 16'd2, 60, 8);
        test_random_traffic(260, 16'($urandom_range(40)), 16'($urandom_range(7)), 20, 2);
        test_random_traffic(260, 16'd12, 16'($urandom_range(65535)), 10, 6);
        $display("Checked %0d result transactions for %0d input items (%0d scan ticks, %0d rejected).",
                 results_checked, items_sent, ticks_sent, rejects_predicted);
        $display("Dwell ran from 0 to 65535 ms and blank slots from 0 to 31 under random stalls.");
        if (err_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
